/* rtl/mdt_pkg.sv */
// Shared constants and types of the multichannel down timer register block.
package mdt_pkg;

    localparam int CHANNELS         = 4;
    localparam int COUNTER_BITS     = 32;
    localparam int CLEAR_BUSY_TICKS = 2;

    localparam int DATA_BITS = 32;
    localparam int CH_BITS   = 2;
    localparam int OFF_BITS  = 4;
    localparam int REQ_BITS  = 2;
    localparam int BUSY_BITS = 2;
    localparam int IRQ_BITS  = 4;

    // Request types.
    localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_TICK  = 2'd2;

    // Word offsets within a channel.
    localparam logic [OFF_BITS-1:0] OFF_STATUS = 4'd0;
    localparam logic [OFF_BITS-1:0] OFF_MODE   = 4'd1;
    localparam logic [OFF_BITS-1:0] OFF_LOAD   = 4'd2;
    localparam logic [OFF_BITS-1:0] OFF_ENABLE = 4'd4;
    localparam logic [OFF_BITS-1:0] OFF_RELOAD = 4'd5;
    localparam logic [OFF_BITS-1:0] OFF_VALUE  = 4'd6;
    localparam logic [OFF_BITS-1:0] OFF_CLEAR  = 4'd8;
    localparam logic [OFF_BITS-1:0] OFF_MASK   = 4'd9;

    localparam logic MODE_CONTINUOUS = 1'b0;

    // Per-channel request derived from one accepted input beat.
    typedef struct packed {
        logic                 tick;
        logic                 wr;
        logic [OFF_BITS-1:0]  off;
        logic [DATA_BITS-1:0] data;
    } t_ch_req;

endpackage

/* rtl/mdt_channel.sv */
// One timer channel: its registers, down counter and interrupt state.
module mdt_channel
    import mdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ch_req              i_req,
    output logic [DATA_BITS-1:0] o_rd_data,
    output logic                 o_pending,
    output logic                 o_irq_next
);

    logic                    r_mode, n_mode;
    logic [COUNTER_BITS-1:0] r_load, n_load;
    logic                    r_en,   n_en;
    logic [COUNTER_BITS-1:0] r_cnt,  n_cnt;
    logic                    r_pend, n_pend;
    logic                    r_mask, n_mask;
    logic [BUSY_BITS-1:0]    r_busy, n_busy;

    always_comb begin
        n_mode = r_mode;
        n_load = r_load;
        n_en   = r_en;
        n_cnt  = r_cnt;
        n_pend = r_pend;
        n_mask = r_mask;
        n_busy = r_busy;
        if (i_req.tick) begin
            if (r_busy != '0) begin
                n_busy = r_busy - BUSY_BITS'(1);
            end
            if (r_en) begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - COUNTER_BITS'(1);
                    if (r_cnt == COUNTER_BITS'(1)) begin
                        n_pend = 1'b1;
                    end
                end else if (r_mode == MODE_CONTINUOUS) begin
                    n_cnt = r_load;
                    if (r_load == '0) begin
                        n_pend = 1'b1;
                    end
                end
            end
        end else if (i_req.wr) begin
            unique case (i_req.off)
                OFF_MODE:   n_mode = i_req.data[0];
                OFF_LOAD:   n_load = i_req.data[COUNTER_BITS-1:0];
                OFF_ENABLE: begin
                    n_en = i_req.data[0];
                    if (i_req.data[0]) begin
                        n_cnt = r_load;
                    end
                end
                OFF_RELOAD: n_cnt = r_load;
                OFF_CLEAR: begin
                    // A clear is dropped while the previous one is still settling.
                    if (i_req.data[0] && r_busy == '0) begin
                        n_pend = 1'b0;
                        n_busy = BUSY_BITS'(CLEAR_BUSY_TICKS);
                    end
                end
                OFF_MASK:   n_mask = i_req.data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CONTINUOUS;
            r_load <= '0;
            r_en   <= 1'b0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_mask <= 1'b1;
            r_busy <= '0;
        end else begin
            r_mode <= n_mode;
            r_load <= n_load;
            r_en   <= n_en;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
            r_mask <= n_mask;
            r_busy <= n_busy;
        end
    end

    // Readback of the channel's own registers; status is assembled above.
    always_comb begin
        unique case (i_req.off)
            OFF_MODE:   o_rd_data = DATA_BITS'(r_mode);
            OFF_LOAD:   o_rd_data = DATA_BITS'(r_load);
            OFF_ENABLE: o_rd_data = DATA_BITS'(r_en);
            OFF_VALUE:  o_rd_data = DATA_BITS'(r_cnt);
            OFF_CLEAR:  o_rd_data = DATA_BITS'({(r_busy != '0), r_pend});
            OFF_MASK:   o_rd_data = DATA_BITS'(r_mask);
            default:    o_rd_data = '0;
        endcase
    end

    assign o_pending  = r_pend;
    assign o_irq_next = n_pend & ~n_mask;

endmodule

/* rtl/multichannel_down_timer_regs.sv */
// Top level of the four-channel down timer register block.
//
// Each input beat is a register read, a register write or one counter tick,
// and it produces exactly one result beat with the read data and the interrupt
// lines as they stand after the beat. The block takes one beat per clock while
// input ready is high: all channel state updates at the edge that accepts the
// beat, and the result is held in an output register backed by one skid
// register, so input is still taken while a result waits. Input ready drops
// only when both are full. There is no clearing pass after reset.
module multichannel_down_timer_regs
    import mdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [REQ_BITS-1:0]  i_req_type,
    input  logic [CH_BITS-1:0]   i_channel,
    input  logic [OFF_BITS-1:0]  i_reg_index,
    input  logic [DATA_BITS-1:0] i_write_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_BITS-1:0] o_read_data,
    output logic [IRQ_BITS-1:0]  o_irq_lines
);

    logic                 w_accept;
    logic                 w_pop;
    t_ch_req              w_req [CHANNELS];
    logic [DATA_BITS-1:0] w_ch_rd [CHANNELS];
    logic [CHANNELS-1:0]  w_pend;
    logic [CHANNELS-1:0]  w_irq_next;
    logic [DATA_BITS-1:0] w_rd;
    logic [IRQ_BITS-1:0]  w_irq;

    logic                 r_out_valid, n_out_valid;
    logic                 r_skid_valid, n_skid_valid;
    logic [DATA_BITS-1:0] r_out_rd, r_skid_rd;
    logic [IRQ_BITS-1:0]  r_out_irq, r_skid_irq;

    assign w_accept = i_in_valid & o_in_ready;
    assign w_pop    = r_out_valid & i_out_ready;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        always_comb begin
            w_req[c].tick = w_accept && (i_req_type == REQ_TICK);
            w_req[c].wr   = w_accept && (i_req_type == REQ_WRITE)
                            && (int'(i_channel) == c);
            w_req[c].off  = i_reg_index;
            w_req[c].data = i_write_data;
        end

        mdt_channel u_channel (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (w_req[c]),
            .o_rd_data  (w_ch_rd[c]),
            .o_pending  (w_pend[c]),
            .o_irq_next (w_irq_next[c])
        );
    end

    // Read data; channel numbers beyond the populated set read as zero.
    always_comb begin
        w_rd = '0;
        if (i_req_type == REQ_READ) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (int'(i_channel) == c) begin
                    w_rd = (i_reg_index == OFF_STATUS) ? DATA_BITS'(w_pend) : w_ch_rd[c];
                end
            end
        end
    end

    always_comb begin
        w_irq = '0;
        for (int c = 0; c < CHANNELS && c < IRQ_BITS; c++) begin
            w_irq[c] = w_irq_next[c];
        end
    end

    // Output register with one skid entry behind it.
    assign o_in_ready = ~r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_accept;
            end
        end else if (!r_out_valid) begin
            n_out_valid = w_accept;
        end else if (w_accept) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_skid_valid) begin
            r_out_rd  <= r_skid_rd;
            r_out_irq <= r_skid_irq;
        end else if ((w_pop || !r_out_valid) && w_accept) begin
            r_out_rd  <= w_rd;
            r_out_irq <= w_irq;
        end
        if (!w_pop && r_out_valid && w_accept) begin
            r_skid_rd  <= w_rd;
            r_skid_irq <= w_irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_rd;
    assign o_irq_lines = r_out_irq;

`ifndef NO_ASSERTIONS
    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // The skid entry fills only from an accepted beat under a stalled output.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(w_accept) && $past(r_out_valid) && !$past(i_out_ready))
        else $error("skid entry filled without a stalled accept");

    // An accepted beat always leaves a result behind it.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted beat produced no result");
`endif

endmodule

/* verif/multichannel_down_timer_regs_tb.sv */
// Self-checking testbench for the four-channel down timer register block.
`timescale 1ns / 100ps

module multichannel_down_timer_regs_tb;
    import mdt_pkg::*;

    // Request code with no function; the block must treat it as a no-op.
    localparam logic [REQ_BITS-1:0] REQ_UNUSED     = 2'd3;
    localparam logic [OFF_BITS-1:0] OFF_UNUSED_TOP = 4'd15;
    localparam int                  MAX_GAP        = 13;
    localparam int                  QUIET_LIMIT    = 1000;
    localparam logic [DATA_BITS-1:0] ALL_ONES      = '1;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic [IRQ_BITS-1:0]  irq_lines;
    } t_timer_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [REQ_BITS-1:0]  i_req_type = '0;
    logic [CH_BITS-1:0]   i_channel = '0;
    logic [OFF_BITS-1:0]  i_reg_index = '0;
    logic [DATA_BITS-1:0] i_write_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [DATA_BITS-1:0] o_read_data;
    logic [IRQ_BITS-1:0]  o_irq_lines;

    multichannel_down_timer_regs DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_channel    (i_channel),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_irq_lines  (o_irq_lines)
    );

    always #1 i_clk = ~i_clk;

    // Predicted timer state, one entry per channel.
    logic                    ch_mode    [CHANNELS];
    logic [COUNTER_BITS-1:0] ch_load    [CHANNELS];
    logic                    ch_en      [CHANNELS];
    logic [COUNTER_BITS-1:0] ch_count   [CHANNELS];
    logic                    ch_pending [CHANNELS];
    logic                    ch_masked  [CHANNELS];
    logic [BUSY_BITS-1:0]    ch_busy    [CHANNELS];

    t_timer_result due_results[$];

    bit no_gaps = 1'b0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    int read_beats = 0;
    int write_beats = 0;
    int tick_beats = 0;
    int other_beats = 0;
    int irq_raises = 0;

    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Mostly small load values so that counters reach zero often.
    function automatic logic [DATA_BITS-1:0] draw_load();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return DATA_BITS'($urandom_range(0, 8));
        if (pick < 85) return DATA_BITS'($urandom_range(0, 40));
        if (pick < 95) return $urandom();
        return ALL_ONES;
    endfunction

    task automatic predict_timer_beat(input logic [REQ_BITS-1:0] req,
                                      input logic [CH_BITS-1:0] ch,
                                      input logic [OFF_BITS-1:0] off,
                                      input logic [DATA_BITS-1:0] data,
                                      output t_timer_result res);
        logic hit;
        res = '0;
        if (req == REQ_READ && int'(ch) < CHANNELS) begin
            case (off)
                OFF_STATUS: begin
                    for (int c = 0; c < CHANNELS; c++) res.read_data[c] = ch_pending[c];
                end
                OFF_MODE:   res.read_data = DATA_BITS'(ch_mode[ch]);
                OFF_LOAD:   res.read_data = DATA_BITS'(ch_load[ch]);
                OFF_ENABLE: res.read_data = DATA_BITS'(ch_en[ch]);
                OFF_VALUE:  res.read_data = DATA_BITS'(ch_count[ch]);
                OFF_CLEAR:  res.read_data = DATA_BITS'({ch_busy[ch] != '0, ch_pending[ch]});
                OFF_MASK:   res.read_data = DATA_BITS'(ch_masked[ch]);
                default:    res.read_data = '0;
            endcase
        end else if (req == REQ_WRITE && int'(ch) < CHANNELS) begin
            case (off)
                OFF_MODE: ch_mode[ch] = data[0];
                OFF_LOAD: ch_load[ch] = data[COUNTER_BITS-1:0];
                OFF_ENABLE: begin
                    ch_en[ch] = data[0];
                    if (data[0]) ch_count[ch] = ch_load[ch];
                end
                OFF_RELOAD: ch_count[ch] = ch_load[ch];
                OFF_CLEAR: begin
                    if (data[0] && ch_busy[ch] == '0) begin
                        ch_pending[ch] = 1'b0;
                        ch_busy[ch] = BUSY_BITS'(CLEAR_BUSY_TICKS);
                    end
                end
                OFF_MASK: ch_masked[ch] = data[0];
                default: ;
            endcase
        end else if (req == REQ_TICK) begin
            for (int c = 0; c < CHANNELS; c++) begin
                hit = 1'b0;
                if (ch_busy[c] != '0) ch_busy[c] = ch_busy[c] - 1'b1;
                if (ch_en[c]) begin
                    if (ch_count[c] != '0) begin
                        ch_count[c] = ch_count[c] - 1'b1;
                        hit = (ch_count[c] == '0);
                    end else if (ch_mode[c] == MODE_CONTINUOUS) begin
                        // Continuous mode reloads on the tick after zero.
                        ch_count[c] = ch_load[c];
                        hit = (ch_count[c] == '0);
                    end
                end
                if (hit) begin
                    if (!ch_pending[c]) irq_raises++;
                    ch_pending[c] = 1'b1;
                end
            end
        end
        for (int c = 0; c < CHANNELS && c < IRQ_BITS; c++)
            res.irq_lines[c] = ch_pending[c] & ~ch_masked[c];
    endtask

    // Presents one beat after a random gap and records its expected result once taken.
    task automatic send_beat(input logic [REQ_BITS-1:0] req, input logic [CH_BITS-1:0] ch,
                             input logic [OFF_BITS-1:0] off, input logic [DATA_BITS-1:0] data);
        int gap;
        t_timer_result res;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_channel    <= ch;
        i_reg_index  <= off;
        i_write_data <= data;
        do @(posedge i_clk); while (!o_in_ready);
        predict_timer_beat(req, ch, off, data, res);
        due_results.push_back(res);
        case (req)
            REQ_READ:  read_beats++;
            REQ_WRITE: write_beats++;
            REQ_TICK:  tick_beats++;
            default:   other_beats++;
        endcase
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stall after every result that is taken.
    always @(posedge i_clk) begin
        if (i_out_ready && o_out_valid) begin
            stall_left = draw_gap();
        end else if (!i_out_ready && stall_left > 0) begin
            stall_left--;
        end
        i_out_ready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: read_data %h irq_lines %h",
                       o_read_data, o_irq_lines);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data mismatch: expected %h, actual %h",
                           want.read_data, o_read_data);
                    mismatch_count++;
                end
                if (o_irq_lines !== want.irq_lines) begin
                    $error("irq_lines mismatch: expected %h, actual %h",
                           want.irq_lines, o_irq_lines);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic test_reset_state();
        send_beat(REQ_READ, 2'd0, OFF_STATUS, '0);
        send_beat(REQ_READ, 2'd1, OFF_MASK, '0);
    endtask

    // Field extremes, read-only registers, unused offsets and the unused request code.
    task automatic test_register_fields();
        send_beat(REQ_WRITE, 2'd1, OFF_LOAD, ALL_ONES);
        send_beat(REQ_READ, 2'd1, OFF_LOAD, '0);
        send_beat(REQ_WRITE, 2'd2, OFF_MODE, ALL_ONES);
        send_beat(REQ_WRITE, 2'd0, OFF_VALUE, ALL_ONES);
        send_beat(REQ_READ, 2'd0, OFF_VALUE, '0);
        send_beat(REQ_WRITE, 2'd3, OFF_UNUSED_TOP, ALL_ONES);
        send_beat(REQ_READ, 2'd3, OFF_UNUSED_TOP, ALL_ONES);
        send_beat(REQ_UNUSED, 2'd3, OFF_UNUSED_TOP, ALL_ONES);
    endtask

    // Single run on channel 0, including a clear that lands while the last one is busy.
    task automatic test_single_run();
        send_beat(REQ_WRITE, 2'd0, OFF_LOAD, 32'd1);
        send_beat(REQ_WRITE, 2'd0, OFF_MODE, 32'd1);
        send_beat(REQ_WRITE, 2'd0, OFF_MASK, 32'd0);
        send_beat(REQ_WRITE, 2'd0, OFF_ENABLE, 32'd1);
        send_beat(REQ_TICK, 2'd0, OFF_STATUS, '0);
        send_beat(REQ_TICK, 2'd0, OFF_STATUS, '0);
        send_beat(REQ_READ, 2'd0, OFF_VALUE, '0);
        send_beat(REQ_WRITE, 2'd0, OFF_CLEAR, 32'd1);
        send_beat(REQ_WRITE, 2'd0, OFF_RELOAD, '0);
        send_beat(REQ_TICK, 2'd0, OFF_STATUS, '0);
        send_beat(REQ_WRITE, 2'd0, OFF_CLEAR, 32'd1);
        send_beat(REQ_READ, 2'd0, OFF_CLEAR, '0);
        send_beat(REQ_TICK, 2'd0, OFF_STATUS, '0);
        send_beat(REQ_READ, 2'd0, OFF_CLEAR, '0);
    endtask

    // Zero load: continuous mode raises on every tick, single mode never does.
    task automatic test_zero_load();
        send_beat(REQ_WRITE, 2'd3, OFF_MASK, 32'd0);
        send_beat(REQ_WRITE, 2'd3, OFF_ENABLE, 32'd1);
        send_beat(REQ_TICK, 2'd3, OFF_STATUS, '0);
        send_beat(REQ_WRITE, 2'd3, OFF_CLEAR, 32'd1);
        send_beat(REQ_TICK, 2'd3, OFF_STATUS, '0);
        send_beat(REQ_READ, 2'd3, OFF_STATUS, '0);
        send_beat(REQ_WRITE, 2'd2, OFF_ENABLE, 32'd1);
        send_beat(REQ_TICK, 2'd2, OFF_STATUS, '0);
        send_beat(REQ_READ, 2'd2, OFF_CLEAR, '0);
    endtask

    // Mix of channel setup sequences and single random beats.
    task automatic test_random_traffic(input int beats);
        int done_beats;
        int pick;
        logic [CH_BITS-1:0]   ch;
        logic [OFF_BITS-1:0]  off;
        logic [REQ_BITS-1:0]  req;
        logic [DATA_BITS-1:0] data;
        done_beats = 0;
        while (done_beats < beats) begin
            ch = CH_BITS'($urandom_range(0, CHANNELS - 1));
            if ($urandom_range(0, 9) < 3) begin
                send_beat(REQ_WRITE, ch, OFF_LOAD, draw_load());
                send_beat(REQ_WRITE, ch, OFF_MODE, $urandom());
                data = $urandom();
                if ($urandom_range(0, 3) != 0) data[0] = 1'b0;
                send_beat(REQ_WRITE, ch, OFF_MASK, data);
                data = $urandom();
                data[0] = ($urandom_range(0, 4) != 0);
                send_beat(REQ_WRITE, ch, OFF_ENABLE, data);
                done_beats += 4;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      req = REQ_TICK;
                else if (pick < 70) req = REQ_WRITE;
                else if (pick < 95) req = REQ_READ;
                else                req = REQ_UNUSED;
                if ($urandom_range(0, 3) == 0) begin
                    off = OFF_BITS'($urandom_range(0, 15));
                end else begin
                    case ($urandom_range(0, 7))
                        0: off = OFF_STATUS;
                        1: off = OFF_MODE;
                        2: off = OFF_LOAD;
                        3: off = OFF_ENABLE;
                        4: off = OFF_RELOAD;
                        5: off = OFF_VALUE;
                        6: off = OFF_CLEAR;
                        default: off = OFF_MASK;
                    endcase
                end
                data = (off == OFF_LOAD) ? draw_load() : $urandom();
                send_beat(req, ch, off, data);
                if (req == REQ_READ || req == REQ_TICK) begin
                    done_beats++;
                end else if (req == REQ_WRITE) begin
                    case (off)
                        OFF_MODE, OFF_LOAD, OFF_ENABLE, OFF_RELOAD, OFF_CLEAR, OFF_MASK:
                            done_beats++;
                        default: ;
                    endcase
                end
            end
        end
    endtask

    // The sender holds off until every outstanding result has drained.
    task automatic test_drain_pause();
        test_random_traffic(150);
        wait_for_results();
        test_random_traffic(150);
    endtask

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            ch_mode[c]    = MODE_CONTINUOUS;
            ch_load[c]    = '0;
            ch_en[c]      = 1'b0;
            ch_count[c]   = '0;
            ch_pending[c] = 1'b0;
            ch_masked[c]  = 1'b1;
            ch_busy[c]    = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_fields();
        test_single_run();
        test_zero_load();
        test_random_traffic(650);
        no_gaps = 1'b1;
        test_random_traffic(400);
        no_gaps = 1'b0;
        test_drain_pause();
        test_random_traffic(650);

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            mismatch_count++;
        end

        $display("Sent %0d beats: %0d reads, %0d writes, %0d ticks, %0d unused requests.",
                 read_beats + write_beats + tick_beats + other_beats,
                 read_beats, write_beats, tick_beats, other_beats);
        $display("All channels and offsets were hit, with %0d interrupt raises predicted.",
                 irq_raises);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
